[rtl/smartcard_atr_parser_macros.svh]
// Assertion helpers for the ATR parser; empty when synthesized.
`ifndef SMARTCARD_ATR_PARSER_MACROS_SVH
`define SMARTCARD_ATR_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define SCATR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SCATR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCATR_ASSERT(lbl, prop, msg)
`define SCATR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/scatr_pkg.sv]
package scatr_pkg;

  typedef enum logic [3:0] {
    PH_PARSING  = 4'b0001,
    PH_COMPLETE = 4'b0010,
    PH_INVALID  = 4'b0100,
    PH_IDLE     = 4'b1000
  } phase_t;

  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;
  localparam logic [3:0] GROUP_T0   = 4'd0;
  localparam logic [3:0] GROUP_1    = 4'd1;
  localparam logic [3:0] GROUP_2    = 4'd2;
  localparam logic [3:0] GROUP_LAST = 4'd15;
  localparam logic [3:0] PROTO_T1   = 4'd1;

  typedef struct packed {
    logic [3:0] hist;
    logic [7:0] fi_di;
    logic [7:0] n;
    logic [7:0] wi;
    logic [7:0] proto;
    logic [7:0] ifsc;
    logic [7:0] cwi_bwi;
    logic [7:0] ii_pi1;
    logic [7:0] pi2;
    logic [2:0] flags;
  } fields_t;

  typedef struct packed {
    logic [1:0] status;
    fields_t    fields;
  } result_t;

  function automatic logic [1:0] status_of(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_PARSING:  code = ST_PARSING;
      PH_COMPLETE: code = ST_COMPLETE;
      PH_INVALID:  code = ST_INVALID;
      default:     code = ST_IDLE;
    endcase
    return code;
  endfunction

endpackage

[rtl/smartcard_atr_parser.sv]
// ATR parser: takes one answer-to-reset byte per transaction and returns one
// result per byte with the parse status and every field decoded so far. A new
// byte is accepted every cycle when the result side keeps up; each byte sits
// in an input register, goes through a single decode step that updates the
// parse state, and lands in the result register when the result side is free.
// The block is ready right after reset; no clearing pass is needed.
module smartcard_atr_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] atr_byte,
  input  logic       start_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [3:0] hist_count,
  output logic [3:0] fi,
  output logic [3:0] di,
  output logic [7:0] guard_n,
  output logic [7:0] wait_wi,
  output logic [7:0] protocols,
  output logic [7:0] ifsc,
  output logic [7:0] cwi_bwi,
  output logic [7:0] ii_pi1,
  output logic [7:0] pi2,
  output logic [2:0] mode_flags
);
  import scatr_pkg::*;

  logic       in_full;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;
  result_t    core_result;
  result_t    result_q;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q  <= atr_byte;
      start_q <= start_req;
    end
  end

  scatr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .atr_byte  (byte_q),
    .start_req (start_q),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign status     = result_q.status;
  assign hist_count = result_q.fields.hist;
  assign fi         = result_q.fields.fi_di[7:4];
  assign di         = result_q.fields.fi_di[3:0];
  assign guard_n    = result_q.fields.n;
  assign wait_wi    = result_q.fields.wi;
  assign protocols  = result_q.fields.proto;
  assign ifsc       = result_q.fields.ifsc;
  assign cwi_bwi    = result_q.fields.cwi_bwi;
  assign ii_pi1     = result_q.fields.ii_pi1;
  assign pi2        = result_q.fields.pi2;
  assign mode_flags = result_q.fields.flags;

endmodule

[rtl/scatr_core.sv]
`include "smartcard_atr_parser_macros.svh"

module scatr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        atr_byte,
  input  logic              start_req,
  output scatr_pkg::result_t result
);
  import scatr_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] pending, pending_next;
  logic [3:0] group, group_next;
  fields_t    fields, fields_next;
  logic [3:0] cur_proto;

  assign cur_proto = fields.proto[3:0];

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    group_next   = group;
    fields_next  = fields;
    if (step) begin
      if (start_req) begin
        pending_next = '0;
        group_next   = GROUP_T0;
        fields_next  = '0;
        phase_next   = (atr_byte == TS_DIRECT || atr_byte == TS_INVERSE) ?
                       PH_PARSING : PH_INVALID;
      end else if (phase == PH_PARSING) begin
        if (group == GROUP_T0) begin
          // T0: historical count and first presence mask
          fields_next.hist = atr_byte[3:0];
          pending_next     = atr_byte[7:4];
          group_next       = GROUP_1;
        end else if (pending[0]) begin
          pending_next[0] = 1'b0;
          if (group == GROUP_1) begin
            fields_next.fi_di = atr_byte;
          end else if (group == GROUP_2) begin
            fields_next.flags = {atr_byte[4], atr_byte[7], 1'b1};
          end else if (cur_proto == PROTO_T1) begin
            fields_next.ifsc = atr_byte;
          end
        end else if (pending[1]) begin
          pending_next[1] = 1'b0;
          if (group == GROUP_1) begin
            fields_next.ii_pi1 = atr_byte;
          end else if (group == GROUP_2) begin
            fields_next.pi2 = atr_byte;
          end else if (cur_proto == PROTO_T1) begin
            fields_next.cwi_bwi = atr_byte;
          end
        end else if (pending[2]) begin
          pending_next[2] = 1'b0;
          if (group == GROUP_1) begin
            fields_next.n = atr_byte;
          end else if (group == GROUP_2) begin
            fields_next.wi = atr_byte;
          end
        end else begin
          // TD: set protocol, chain to the next group
          if (group == GROUP_1) begin
            fields_next.proto = {atr_byte[3:0], atr_byte[3:0]};
          end else begin
            fields_next.proto[3:0] = atr_byte[3:0];
          end
          pending_next = atr_byte[7:4];
          if (group != GROUP_LAST) begin
            group_next = group + 4'd1;
          end
        end
        if (pending_next == 4'd0) begin
          phase_next = PH_COMPLETE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= '0;
      group   <= GROUP_T0;
      fields  <= '0;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
      group   <= group_next;
      fields  <= fields_next;
    end
  end

  assign result = '{status: status_of(phase_next), fields: fields_next};

  `SCATR_ASSERT(a_complete_no_pending, (phase != PH_COMPLETE) || (pending == 4'd0), "complete with interface bytes pending")
  `SCATR_ASSERT(a_invalid_cleared, (phase != PH_INVALID) || (fields == '0 && group == GROUP_T0), "invalid TS left fields set")
  `SCATR_ASSERT_NEXT(a_ts_starts_parse, step && start_req && (atr_byte == TS_DIRECT || atr_byte == TS_INVERSE), phase == PH_PARSING && group == GROUP_T0, "valid TS did not start parsing")

endmodule
